### sv/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; the clock and reset are passed in as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AST_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/fpa_pkg.sv
// Package for the fixed-point ALU: word width, defaults, mode codes, item type.
// Depends on nothing.
`default_nettype none
package fpa_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int MODE_BITS     = 4;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD     = 4'd0,
    MODE_SUB     = 4'd1,
    MODE_MUL     = 4'd2,
    MODE_DIV     = 4'd3,
    MODE_GT      = 4'd4,
    MODE_LT      = 4'd5,
    MODE_GE      = 4'd6,
    MODE_LE      = 4'd7,
    MODE_EQ      = 4'd8,
    MODE_NE      = 4'd9,
    MODE_MAX     = 4'd10,
    MODE_MIN     = 4'd11,
    MODE_INC     = 4'd12,
    MODE_DEC     = 4'd13,
    MODE_TO_INT  = 4'd14,
    MODE_FROM_INT = 4'd15
  } mode_t;

  typedef struct packed {
    mode_t                        mode;
    logic signed [WORD_BITS-1:0]  operand_a;
    logic signed [WORD_BITS-1:0]  operand_b;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage
`default_nettype wire

### sv/fpa_front.sv
// Front queue of the fixed-point ALU: takes input beats into a two-entry queue.
// Depends on fpa_pkg.
`default_nettype none
module fpa_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire fpa_pkg::item_t in_item,
  output fpa_pkg::head_t      head,
  input  wire logic           take
);

  fpa_pkg::item_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign do_push    = push && !full;
  assign do_pop     = take && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

### sv/fpa_back.sv
// Back pipeline of the fixed-point ALU: decode stage, one divider stage per
// quotient bit, and an output register. Depends on fpa_pkg.
`default_nettype none
module fpa_back #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire fpa_pkg::head_t head,
  output logic                take,
  output logic                empty,
  input  wire logic           pop,
  output logic signed [fpa_pkg::WORD_BITS-1:0] result_value,
  output logic                compare_true,
  output logic                divide_by_zero
);

  localparam int W  = fpa_pkg::WORD_BITS;
  localparam int NW = W + FRAC_BITS;

  typedef struct packed {
    fpa_pkg::mode_t  mode;
    logic [W-1:0]    res;
    logic            cmp;
    logic            dz;
    logic            neg;
    logic [2*W-1:0]  prod;
    logic [NW-1:0]   num;
    logic [W:0]      rem;
    logic [NW-1:0]   quo;
    logic [W-1:0]    dvs;
  } stage_t;

  stage_t         pipe_r [NW+1];
  logic           vld_r  [NW+1];
  stage_t         s0_nxt;
  stage_t         step_nxt [NW];
  logic [W-1:0]   res_r, res_nxt;
  logic           cmp_r, dz_r, vout_r;
  logic           en;
  logic [W-1:0]   a, b, ma, mb, tq;
  logic           lt_ab, lt_ba;
  logic [NW-1:0]  qfin;

  assign en             = !vout_r || pop;
  assign take           = en;
  assign empty          = !vout_r;
  assign result_value   = res_r;
  assign compare_true   = cmp_r;
  assign divide_by_zero = dz_r;

  always_comb begin
    a     = head.item.operand_a;
    b     = head.item.operand_b;
    ma    = a[W-1] ? (~a + 1'b1) : a;
    mb    = b[W-1] ? (~b + 1'b1) : b;
    lt_ab = $signed(a) < $signed(b);
    lt_ba = $signed(b) < $signed(a);
    tq    = ma >> FRAC_BITS;
    s0_nxt      = '0;
    s0_nxt.mode = head.item.mode;
    s0_nxt.neg  = a[W-1] ^ b[W-1];
    s0_nxt.prod = (2*W)'($signed(a) * $signed(b));
    s0_nxt.num  = NW'(ma) << FRAC_BITS;
    s0_nxt.dvs  = mb;
    case (head.item.mode)
      fpa_pkg::MODE_ADD:      s0_nxt.res = a + b;
      fpa_pkg::MODE_SUB:      s0_nxt.res = a - b;
      fpa_pkg::MODE_DIV:      s0_nxt.dz  = (b == '0);
      fpa_pkg::MODE_GT:       s0_nxt.cmp = lt_ba;
      fpa_pkg::MODE_LT:       s0_nxt.cmp = lt_ab;
      fpa_pkg::MODE_GE:       s0_nxt.cmp = !lt_ab;
      fpa_pkg::MODE_LE:       s0_nxt.cmp = !lt_ba;
      fpa_pkg::MODE_EQ:       s0_nxt.cmp = (a == b);
      fpa_pkg::MODE_NE:       s0_nxt.cmp = (a != b);
      fpa_pkg::MODE_MAX:      s0_nxt.res = lt_ba ? a : b;
      fpa_pkg::MODE_MIN:      s0_nxt.res = lt_ab ? a : b;
      fpa_pkg::MODE_INC:      s0_nxt.res = a + 1'b1;
      fpa_pkg::MODE_DEC:      s0_nxt.res = a - 1'b1;
      fpa_pkg::MODE_TO_INT:   s0_nxt.res = a[W-1] ? (~tq + 1'b1) : tq;
      fpa_pkg::MODE_FROM_INT: s0_nxt.res = a << FRAC_BITS;
      default:                s0_nxt.res = '0;
    endcase
  end

  // One restoring division step per stage, most significant numerator bit first.
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [W:0] rem_sh;
    logic       ge;
    always_comb begin
      rem_sh = {pipe_r[k].rem[W-1:0], pipe_r[k].num[NW-1]};
      ge     = rem_sh >= {1'b0, pipe_r[k].dvs};
      step_nxt[k]     = pipe_r[k];
      step_nxt[k].rem = ge ? (rem_sh - {1'b0, pipe_r[k].dvs}) : rem_sh;
      step_nxt[k].quo = {pipe_r[k].quo[NW-2:0], ge};
      step_nxt[k].num = pipe_r[k].num << 1;
    end
  end

  always_comb begin
    qfin = pipe_r[NW].neg ? (~pipe_r[NW].quo + 1'b1) : pipe_r[NW].quo;
    case (pipe_r[NW].mode)
      fpa_pkg::MODE_MUL: res_nxt = pipe_r[NW].prod[FRAC_BITS+W-1:FRAC_BITS];
      fpa_pkg::MODE_DIV: res_nxt = pipe_r[NW].dz ? '0 : qfin[W-1:0];
      default:           res_nxt = pipe_r[NW].res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NW; i++) begin
        vld_r[i] <= 1'b0;
      end
      vout_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= head.valid;
      for (int i = 1; i <= NW; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      vout_r <= vld_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= s0_nxt;
      for (int i = 1; i <= NW; i++) begin
        pipe_r[i] <= step_nxt[i-1];
      end
      res_r <= res_nxt;
      cmp_r <= pipe_r[NW].cmp;
      dz_r  <= pipe_r[NW].dz;
    end
  end

endmodule
`default_nettype wire

### sv/fixed_point_alu.sv
// Signed fixed-point ALU on 32-bit words with FRAC_BITS fraction bits. It takes
// one beat per cycle while no result waits unpopped and returns one result beat
// for each, in order. Every beat passes a two-entry input queue and a pipeline
// of FRAC_BITS+34 stages (decode, one stage per quotient bit of the divider,
// output register). The whole pipeline holds while its output is not popped.
// Depends on fpa_pkg, fpa_front and fpa_back.
`default_nettype none
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [fpa_pkg::MODE_BITS-1:0]        in_mode,
  input  wire logic signed [fpa_pkg::WORD_BITS-1:0] in_operand_a,
  input  wire logic signed [fpa_pkg::WORD_BITS-1:0] in_operand_b,
  output logic             empty,
  input  wire logic        pop,
  output logic signed [fpa_pkg::WORD_BITS-1:0]      out_result_value,
  output logic             out_compare_true,
  output logic             out_divide_by_zero
);

  fpa_pkg::item_t in_item;
  fpa_pkg::head_t head;
  logic           take;

  assign in_item.mode      = fpa_pkg::mode_t'(in_mode);
  assign in_item.operand_a = in_operand_a;
  assign in_item.operand_b = in_operand_b;

  fpa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .head    (head),
    .take    (take)
  );

  fpa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .take           (take),
    .empty          (empty),
    .pop            (pop),
    .result_value   (out_result_value),
    .compare_true   (out_compare_true),
    .divide_by_zero (out_divide_by_zero)
  );

endmodule
`default_nettype wire

### sv/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fpa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] out_result_value,
  input wire logic        out_compare_true,
  input wire logic        out_divide_by_zero
);

  `AST_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, empty)
  `AST_NEXT(a_hold_beat, clk, rst_n, !empty && !pop, !empty && $stable(out_result_value))
  `AST_IMPLY(a_dz_zero, clk, rst_n, !empty && out_divide_by_zero, out_result_value == '0)
  `AST_IMPLY(a_cmp_zero, clk, rst_n, !empty && out_compare_true, out_result_value == '0)
  `AST_IMPLY(a_flags_excl, clk, rst_n, !empty, !(out_compare_true && out_divide_by_zero))

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .empty              (empty),
  .pop                (pop),
  .out_result_value   (out_result_value),
  .out_compare_true   (out_compare_true),
  .out_divide_by_zero (out_divide_by_zero)
);
`default_nettype wire

### sim/fixed_point_alu_checker.sv
// Checker for the fixed-point ALU: watches the push and pop beats, predicts each result
// and compares it field by field. Depends on fpa_pkg.
`default_nettype none
module fixed_point_alu_checker #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [3:0]  in_mode,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [31:0] out_result_value,
  input  wire logic        out_compare_true,
  input  wire logic        out_divide_by_zero,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic alu_result_t compute_alu(fpa_pkg::mode_t mode, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    logic [31:0] mag;
    r = '0;
    case (mode)
      fpa_pkg::MODE_ADD: r.value = a + b;
      fpa_pkg::MODE_SUB: r.value = a - b;
      fpa_pkg::MODE_MUL: begin
        prod = 64'(a) * 64'(b);
        r.value = 32'(prod >>> FRAC_BITS);
      end
      fpa_pkg::MODE_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = 64'(a) <<< FRAC_BITS;
          quo = num / 64'(b);
          r.value = quo[31:0];
        end
      end
      fpa_pkg::MODE_GT: r.cmp = a > b;
      fpa_pkg::MODE_LT: r.cmp = a < b;
      fpa_pkg::MODE_GE: r.cmp = a >= b;
      fpa_pkg::MODE_LE: r.cmp = a <= b;
      fpa_pkg::MODE_EQ: r.cmp = a == b;
      fpa_pkg::MODE_NE: r.cmp = a != b;
      fpa_pkg::MODE_MAX: r.value = (a > b) ? a : b;
      fpa_pkg::MODE_MIN: r.value = (a < b) ? a : b;
      fpa_pkg::MODE_INC: r.value = a + 1;
      fpa_pkg::MODE_DEC: r.value = a - 1;
      fpa_pkg::MODE_TO_INT: begin
        mag = a[31] ? -a : a;
        mag = mag >> FRAC_BITS;
        r.value = a[31] ? -mag : mag;
      end
      default: r.value = a << FRAC_BITS;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result beat %0d: %s got %h expected %h", result_count, what, got,
             want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n) begin
      if (push && !full) begin
        expected_results.push_back(compute_alu(fpa_pkg::mode_t'(in_mode), in_operand_a,
                                               in_operand_b));
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", out_result_value, 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (out_result_value !== want.value) begin
            report_mismatch("result_value", out_result_value, want.value);
          end
          if (out_compare_true !== want.cmp) begin
            report_mismatch("compare_true", 32'(out_compare_true), 32'(want.cmp));
          end
          if (out_divide_by_zero !== want.dz) begin
            report_mismatch("divide_by_zero", 32'(out_divide_by_zero), 32'(want.dz));
          end
        end
        result_count++;
      end
    end
    pending_count = expected_results.size();
  end
endmodule
`default_nettype wire

### sim/fixed_point_alu_tb.sv
// Testbench top for the fixed-point ALU: directed and random operations with random
// stalls on both sides. Depends on fpa_pkg, fixed_point_alu and fixed_point_alu_checker.
`default_nettype none
module fixed_point_alu_tb;

  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [3:0]  in_mode = '0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        full;
  logic        empty;
  logic [31:0] out_result_value;
  logic        out_compare_true;
  logic        out_divide_by_zero;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          idle_cycles = 0;
  int          beats_sent = 0;
  bit          calm = 1'b0;

  always #5 clk = ~clk;

  fixed_point_alu dut (.*);

  fixed_point_alu_checker checker_i (.*);

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
      4: return 32'($signed($urandom_range(0, 4096)) - 2048);
      5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(fpa_pkg::mode_t mode, logic [31:0] a, logic [31:0] b);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_mode <= mode;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap - 1) @(negedge clk);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int m = 0; m < 16; m++) begin
      send_beat(fpa_pkg::mode_t'(m), edges[m % 6], edges[(m + 1) % 6]);
    end
    send_beat(fpa_pkg::MODE_DIV, 32'h1234, 32'h0);
    send_beat(fpa_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(fpa_pkg::MODE_MAX, 32'h500, 32'h500);
    send_beat(fpa_pkg::MODE_TO_INT, 32'hffff_fe80, 32'h0);
    send_beat(fpa_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000);
    send_beat(fpa_pkg::MODE_EQ, 32'h77, 32'h77);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 100) calm = 1'b1;
      send_beat(fpa_pkg::mode_t'($urandom_range(0, 15)), pick_operand(),
                ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
    end
    push <= 1'b0;
    calm = 1'b1;
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d beats across all sixteen modes, including edge operands and zero",
             beats_sent);
    $display("divisors; %0d result beats were checked.", result_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/fpa_pkg.sv
sv/fpa_front.sv
sv/fpa_back.sv
sv/fixed_point_alu.sv
sv/fpa_checker.sv
sim/fixed_point_alu_checker.sv
sim/fixed_point_alu_tb.sv
